@@ rtl/abm_pkg.sv @@
// ============================================================================
// abm_pkg - shared types and constants for the apnea breath monitor
// Holds the transaction structs, configuration layout and command codes.
// ============================================================================
package abm_pkg;

    // Time base of the breath and sample timers (16 to 64 bits).
    localparam int TIME_WIDTH = 32;
    // Width at which elapsed times are compared against the configured limits.
    localparam int CMP_W      = (TIME_WIDTH > 20) ? TIME_WIDTH : 20;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    typedef logic [TIME_WIDTH-1:0] abm_time_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SAMPLE_INTERVAL = 3'd0,
        CFG_BREATH_THRESH   = 3'd1,
        CFG_DEBOUNCE_LIMIT  = 3'd2,
        CFG_APNEA_TIMEOUT   = 3'd3,
        CFG_SUSPEND         = 3'd4
    } abm_cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd50;
    localparam logic [9:0]  BREATH_THRESH_RST   = 10'd512;
    localparam logic [7:0]  DEBOUNCE_LIMIT_RST  = 8'd3;
    localparam logic [19:0] APNEA_TIMEOUT_RST   = 20'd20000;

    // Input commands.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic [9:0]  sample;
        logic        alarm_sounding;
    } abm_in_t;

    typedef struct packed {
        logic raise_alarm;
        logic breath_edge;
        logic breath_phase;
    } abm_out_t;

    typedef struct packed {
        logic [15:0] sample_interval_ms;
        logic [9:0]  breath_threshold;
        logic [7:0]  debounce_limit;
        logic [19:0] apnea_timeout_ms;
        logic        monitor_suspended;
    } abm_cfg_t;

endpackage

@@ rtl/abm_cfg_regs.sv @@
// ============================================================================
// abm_cfg_regs - configuration register file
// Write-only registers loaded from the plain configuration write port.
// ============================================================================
module abm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [abm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output abm_pkg::abm_cfg_t              cfg
);
    import abm_pkg::*;

    abm_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval_ms <= SAMPLE_INTERVAL_RST;
            cfg_reg.breath_threshold   <= BREATH_THRESH_RST;
            cfg_reg.debounce_limit     <= DEBOUNCE_LIMIT_RST;
            cfg_reg.apnea_timeout_ms   <= APNEA_TIMEOUT_RST;
            cfg_reg.monitor_suspended  <= 1'b0;
        end
        else if (cfg_we)
        begin
            // Drop writes to unknown indexes.
            case (abm_cfg_index_t'(cfg_index))
                CFG_SAMPLE_INTERVAL: cfg_reg.sample_interval_ms <= cfg_wdata[15:0];
                CFG_BREATH_THRESH:   cfg_reg.breath_threshold   <= cfg_wdata[9:0];
                CFG_DEBOUNCE_LIMIT:  cfg_reg.debounce_limit     <= cfg_wdata[7:0];
                CFG_APNEA_TIMEOUT:   cfg_reg.apnea_timeout_ms   <= cfg_wdata[19:0];
                CFG_SUSPEND:         cfg_reg.monitor_suspended  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/abm_detector.sv @@
// ============================================================================
// abm_detector - breath phase detector and apnea timer
// Evaluates one registered transaction per cycle and updates the monitor state only while fire is high.
// ============================================================================
module abm_detector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  abm_pkg::abm_in_t  item,
    input  abm_pkg::abm_cfg_t cfg,
    output abm_pkg::abm_out_t result
);
    import abm_pkg::*;

    abm_time_t  last_sample_time_reg, last_sample_time_next;
    abm_time_t  breath_timer_start_reg, breath_timer_start_next;
    logic [7:0] qualify_count_reg, qualify_count_next;
    logic       phase_reg, phase_next;

    abm_time_t  now;
    abm_time_t  sample_elapsed;
    abm_time_t  breath_elapsed;
    logic       active;
    logic       evaluate;
    logic       hit;
    logic [7:0] count_upd;
    logic       flip;

    assign now            = TIME_WIDTH'(item.now_ms);
    assign active         = (item.command == CMD_TICK) && !item.alarm_sounding
                            && !cfg.monitor_suspended;
    assign sample_elapsed = now - last_sample_time_reg;
    assign evaluate       = active
                            && (CMP_W'(sample_elapsed) > CMP_W'(cfg.sample_interval_ms));

    // Phase 1 waits for a rise above the threshold, phase 0 for a fall below.
    assign hit = phase_reg ? (item.sample > cfg.breath_threshold)
                           : (item.sample < cfg.breath_threshold);

    always_comb
    begin
        if (!hit)
            count_upd = '0;
        else if (qualify_count_reg == COUNT_MAX)
            count_upd = qualify_count_reg;
        else
            count_upd = qualify_count_reg + 8'd1;
    end

    assign flip = evaluate && (count_upd >= cfg.debounce_limit);

    always_comb
    begin
        last_sample_time_next   = last_sample_time_reg;
        breath_timer_start_next = breath_timer_start_reg;
        qualify_count_next      = qualify_count_reg;
        phase_next              = phase_reg;
        if (item.command == CMD_RESET)
        begin
            last_sample_time_next   = now;
            breath_timer_start_next = now;
        end
        else if (evaluate)
        begin
            last_sample_time_next = now;
            qualify_count_next    = flip ? 8'd0 : count_upd;
            if (flip)
            begin
                phase_next              = !phase_reg;
                breath_timer_start_next = now;
            end
        end
    end

    // Timeout check sees the breath timer after this transaction's restart.
    assign breath_elapsed = now - breath_timer_start_next;

    assign result.raise_alarm  = active
                                 && (CMP_W'(breath_elapsed) > CMP_W'(cfg.apnea_timeout_ms));
    assign result.breath_edge  = flip;
    assign result.breath_phase = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_time_reg   <= '0;
            breath_timer_start_reg <= '0;
            qualify_count_reg      <= '0;
            phase_reg              <= 1'b0;
        end
        else if (fire)
        begin
            last_sample_time_reg   <= last_sample_time_next;
            breath_timer_start_reg <= breath_timer_start_next;
            qualify_count_reg      <= qualify_count_next;
            phase_reg              <= phase_next;
        end
    end

endmodule

@@ rtl/apnea_breath_monitor.sv @@
// ============================================================================
// apnea_breath_monitor - breath phase detector with apnea timeout
// Top level: input register, detector, result register and config registers.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per
//   tick or timer reset command. Output channel (out_valid/out_ready/out_data)
//   returns exactly one result transaction for each input transaction, in
//   order.
//   The configuration port (cfg_we/cfg_index/cfg_wdata) writes one
//   register; write it only while no transaction is in flight.
// Path: the accepted transaction sits in the input register, the detector
//   evaluates it combinationally, and the result register loads its result
//   when the result register is empty or its transaction is being taken.
// Throughput: one transaction per cycle while out_ready stays high. The
//   detector state update is a single subtract, compare and counter step, so
//   each transaction closes its state update; the next may follow directly.
// Reset: rst_n clears both timers, the debounce counter and the phase, loads
//   the configuration reset values and empties both registers.
// Stall: when out_ready is low the result register holds its transaction;
//   an empty input register still takes one more transaction, then in_ready
//   drops until the result is taken.
// ============================================================================
module apnea_breath_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  abm_pkg::abm_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output abm_pkg::abm_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [abm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import abm_pkg::*;

    abm_cfg_t cfg;

    logic     in_valid_reg;
    abm_in_t  in_data_reg;
    logic     out_valid_reg;
    abm_out_t out_data_reg;

    abm_out_t result;
    logic     out_free;
    logic     advance;

    // Result register can load when empty or when its transaction leaves now.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    abm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    abm_detector u_detector (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Control: valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload: hold while stalled, load on handshake or advance.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/abm_checker.sv @@
// ============================================================================
// abm_checker - port-level checks for the apnea breath monitor
// Watches the top-level ports over time; attached by bind.
// ============================================================================
module abm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input abm_pkg::abm_out_t out_data
);
    import abm_pkg::*;

    // An empty result register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with result register empty");

    // A stalled result transaction holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    // A result leaves only through a handshake.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without handshake");

    // A phase flip restarts the breath timer, so it cannot raise the alarm.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.breath_edge |-> !out_data.raise_alarm)
        else $error("alarm raised on a breath edge");

endmodule

bind apnea_breath_monitor abm_checker u_abm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ verif/apnea_breath_monitor_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// apnea_breath_monitor_tb - self-checking testbench for the apnea breath monitor
// Feeds tick and timer-reset transactions through a valid/ready driver. A
// behavioral predictor computes each result as the transaction is accepted,
// and a monitor checks the result stream field by field. Runs a directed
// sequence first, then randomized breathing patterns under several register
// settings, with random stalls on both channels.
// ============================================================================
module apnea_breath_monitor_tb;
    import abm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 19;
    // Two register stages inside the block; leave some margin on top.
    localparam int DRAIN_CYCLES = 6;
    localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_INDEX = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] LAST_SPARE_INDEX  = '1;
    localparam logic [9:0]             SAMPLE_MAX        = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    abm_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    abm_out_t               out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Transactions waiting for the driver, and results waiting for the monitor.
    abm_in_t   pending_items[$];
    abm_out_t  expected_results[$];

    // Predictor copy of the registers and of the detector state.
    abm_cfg_t   cfg_shadow;
    abm_time_t  last_eval_time;
    abm_time_t  breath_start_time;
    logic [7:0] qualify_run;
    logic       phase_now;

    // Breathing pattern generator state.
    logic [31:0] gen_time;
    logic        gen_high;
    int          gen_left;

    int idle_pct    = IDLE_PCT;
    int failures    = 0;
    int cycle_count = 0;

    apnea_breath_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: advance the detector state by one transaction and return the
    // result it produces. Every transaction produces exactly one result.
    // ------------------------------------------------------------------------
    function automatic abm_out_t predict_breath(input abm_in_t item);
        abm_time_t now;
        logic      hit;
        abm_out_t  res;
        now = abm_time_t'(item.now_ms);
        res = '0;
        if (item.command == CMD_RESET) begin
            // Restart both timers; keep the counter and the phase.
            last_eval_time    = now;
            breath_start_time = now;
        end
        else if (!item.alarm_sounding && !cfg_shadow.monitor_suspended) begin
            // Evaluate only once strictly more than the interval has passed.
            if (abm_time_t'(now - last_eval_time) > cfg_shadow.sample_interval_ms) begin
                // Phase 1 looks for a rise above the threshold, phase 0 for a
                // fall below it; a sample equal to the threshold never counts.
                if (phase_now)
                    hit = item.sample > cfg_shadow.breath_threshold;
                else
                    hit = item.sample < cfg_shadow.breath_threshold;
                if (hit) begin
                    if (qualify_run != COUNT_MAX)
                        qualify_run = qualify_run + 1'b1;
                end
                else begin
                    qualify_run = '0;
                end
                // Compare after the update: a limit of zero flips on every
                // evaluation, and a lowered limit flips on the next hit.
                if (qualify_run >= cfg_shadow.debounce_limit) begin
                    phase_now         = ~phase_now;
                    breath_start_time = now;
                    qualify_run       = '0;
                    res.breath_edge   = 1'b1;
                end
                last_eval_time = now;
            end
            // The timeout check runs on every tick that is not ignored, evaluated or not.
            if (abm_time_t'(now - breath_start_time) > cfg_shadow.apnea_timeout_ms)
                res.raise_alarm = 1'b1;
        end
        res.breath_phase = phase_now;
        return res;
    endfunction

    function automatic abm_in_t make_item(input logic cmd, input logic [31:0] now,
                                          input logic [9:0] smp, input logic snd);
        abm_in_t it;
        it.command        = cmd;
        it.now_ms         = now;
        it.sample         = smp;
        it.alarm_sounding = snd;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Queue a breathing pattern: runs of samples on alternating sides of the
    // threshold, a bit longer than the debounce limit, with the time mostly
    // stepping past the sample interval. Mix in early ticks, long gaps that
    // trip the apnea timeout, wild time jumps, noise samples, timer resets
    // and ticks with the external alarm sounding.
    // ------------------------------------------------------------------------
    task automatic queue_breathing(input int count);
        int          pick;
        int          interval;
        int          thr;
        logic [31:0] time_step;
        logic [9:0]  smp;
        logic        cmd;
        logic        snd;
        interval = cfg_shadow.sample_interval_ms;
        thr      = cfg_shadow.breath_threshold;
        // Start in the direction the detector is currently looking for.
        gen_high = phase_now;
        gen_left = cfg_shadow.debounce_limit + $urandom_range(1, 4);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 70)
                time_step = interval + 1 + $urandom_range(0, interval / 4 + 3);
            else if (pick < 85)
                time_step = $urandom_range(0, interval);
            else if (pick < 95)
                time_step = cfg_shadow.apnea_timeout_ms + $urandom_range(0, 3) - 1;
            else
                time_step = $urandom;
            gen_time = gen_time + time_step;

            if ($urandom_range(99) < 8) begin
                // Noise: either exactly on the threshold or anywhere at all.
                smp = $urandom_range(1) ? cfg_shadow.breath_threshold : 10'($urandom);
            end
            else begin
                if (gen_high)
                    smp = (thr == SAMPLE_MAX) ? SAMPLE_MAX
                                              : 10'($urandom_range(thr + 1, SAMPLE_MAX));
                else
                    smp = (thr == 0) ? '0 : 10'($urandom_range(0, thr - 1));
                gen_left--;
                if (gen_left <= 0) begin
                    gen_high = ~gen_high;
                    gen_left = cfg_shadow.debounce_limit + $urandom_range(1, 4);
                end
            end

            cmd = ($urandom_range(99) < 3) ? CMD_RESET : CMD_TICK;
            snd = ($urandom_range(99) < 6);
            pending_items.push_back(make_item(cmd, gen_time, smp, snd));
        end
    endtask

    // Write one register and mirror it in the predictor. Spare indexes are
    // dropped by the block, so drop them here too.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SAMPLE_INTERVAL: cfg_shadow.sample_interval_ms = data[15:0];
            CFG_BREATH_THRESH:   cfg_shadow.breath_threshold   = data[9:0];
            CFG_DEBOUNCE_LIMIT:  cfg_shadow.debounce_limit     = data[7:0];
            CFG_APNEA_TIMEOUT:   cfg_shadow.apnea_timeout_ms   = data[19:0];
            CFG_SUSPEND:         cfg_shadow.monitor_suspended  = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int interval, input int thr, input int limit,
                                  input int timeout, input int suspend);
        write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'(interval));
        write_reg(CFG_BREATH_THRESH,   CFG_DATA_W'(thr));
        write_reg(CFG_DEBOUNCE_LIMIT,  CFG_DATA_W'(limit));
        write_reg(CFG_APNEA_TIMEOUT,   CFG_DATA_W'(timeout));
        write_reg(CFG_SUSPEND,         CFG_DATA_W'(suspend));
    endtask

    // Hit a spare index with random data; the predictor ignores it.
    task automatic write_spare();
        write_reg(CFG_INDEX_W'($urandom_range(FIRST_SPARE_INDEX, LAST_SPARE_INDEX)),
                  CFG_DATA_W'($urandom));
    endtask

    // Wait until every queued transaction has gone in and every result has
    // come back, then let the pipeline settle.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict on acceptance, then load the next transaction or idle.
    // Hold valid and payload until the transaction is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_breath(in_data));
            if (!in_valid || in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation and
    // stall the result channel at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : result_monitor
        abm_out_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", out_data);
                    failures++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_bit("raise_alarm",  want.raise_alarm,  out_data.raise_alarm);
                    check_bit("breath_edge",  want.breath_edge,  out_data.breath_edge);
                    check_bit("breath_phase", want.breath_phase, out_data.breath_phase);
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: give up if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[apnea_breath_monitor] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_shadow.sample_interval_ms = SAMPLE_INTERVAL_RST;
        cfg_shadow.breath_threshold   = BREATH_THRESH_RST;
        cfg_shadow.debounce_limit     = DEBOUNCE_LIMIT_RST;
        cfg_shadow.apnea_timeout_ms   = APNEA_TIMEOUT_RST;
        cfg_shadow.monitor_suspended  = 1'b0;
        last_eval_time    = '0;
        breath_start_time = '0;
        qualify_run       = '0;
        phase_now         = 1'b0;
        gen_time          = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings (interval 50, threshold 512,
        // debounce 3, timeout 20000).
        // First tick at time zero: interval not yet elapsed.
        pending_items.push_back(make_item(CMD_TICK, 32'd0,     10'd0,    1'b0));
        // Three falls below the threshold flip the phase; the tick exactly
        // one interval later is not evaluated.
        pending_items.push_back(make_item(CMD_TICK, 32'd51,    10'd0,    1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'd101,   10'd511,  1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'd102,   10'd511,  1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'd153,   10'd0,    1'b0));
        // Sample on the threshold: no hit either way.
        pending_items.push_back(make_item(CMD_TICK, 32'd204,   10'd512,  1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'd255,   SAMPLE_MAX, 1'b0));
        // External alarm sounding: the tick is ignored.
        pending_items.push_back(make_item(CMD_TICK, 32'd306,   SAMPLE_MAX, 1'b1));
        pending_items.push_back(make_item(CMD_TICK, 32'd357,   10'd600,  1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'd408,   10'd513,  1'b0));
        // Apnea timeout: exactly at the limit, then one past it.
        pending_items.push_back(make_item(CMD_TICK, 32'd20408, SAMPLE_MAX, 1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'd20409, 10'd700,  1'b0));
        // Timer reset just below the wrap point, then ticks across the wrap.
        pending_items.push_back(make_item(CMD_RESET, 32'hFFFF_FFC0, SAMPLE_MAX, 1'b1));
        pending_items.push_back(make_item(CMD_TICK, 32'h0000_0000, 10'd0, 1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'hFFFF_FFFF, 10'd0, 1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'h0000_0040, 10'd0, 1'b0));
        // Alternating bit patterns on time and sample.
        pending_items.push_back(make_item(CMD_TICK, 32'hAAAA_AAAA, 10'h2AA, 1'b0));
        pending_items.push_back(make_item(CMD_TICK, 32'h5555_5555, 10'h155, 1'b0));
        pending_items.push_back(make_item(CMD_RESET, 32'h1234_5678, 10'h0F0, 1'b0));
        drain();

        // Low extremes: no interval, threshold zero, limit one, no timeout.
        apply_settings(0, 0, 1, 0, 0);
        queue_breathing(80);
        drain();

        // High extremes: longest interval, top threshold, largest limit and
        // the full timeout field.
        apply_settings(65535, 1023, 255, (1 << CFG_DATA_W) - 1, 0);
        queue_breathing(60);
        drain();

        // Debounce limit of zero: every evaluation flips the phase.
        apply_settings(10, 300, 0, 1000, 0);
        write_spare();
        queue_breathing(80);
        drain();

        // Build a long run of hits under the largest limit ...
        apply_settings(20, 700, 255, 600000, 0);
        queue_breathing(120);
        drain();

        // ... then lower the limit below the count: the next hit flips.
        write_reg(CFG_DEBOUNCE_LIMIT, CFG_DATA_W'(4));
        queue_breathing(80);
        drain();

        // Suspended: all ticks are ignored, resets still restart the timers.
        write_reg(CFG_SUSPEND, CFG_DATA_W'(1));
        queue_breathing(40);
        drain();

        // Back to defaults with no idling on either side.
        idle_pct = 0;
        apply_settings(50, 512, 3, 20000, 0);
        queue_breathing(150);
        drain();
        idle_pct = IDLE_PCT;

        apply_settings(1000, 100, 2, 5000, 0);
        write_spare();
        queue_breathing(120);
        drain();

        if (failures == 0 && expected_results.size() == 0)
            $display("[apnea_breath_monitor] OK");
        else
            $display("[apnea_breath_monitor] ERROR");
        $finish;
    end

endmodule
